// File: design/btpl_pkg.sv
// Shared types and constants for the binary trie prefix lookup block.
// No dependencies; imported by every module of the block.
package btpl_pkg;

	localparam int ADDR_BITS = 32;
	localparam int DEPTH_BITS = 6;
	localparam int NODE_COUNT_DEF = 4096;
	localparam int PORT_BITS_DEF = 16;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [31:0] ip_address;
		logic [5:0]  prefix_length;
		logic [15:0] route_port;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic [15:0] port;
		logic        status;
	} out_item_t;

endpackage

// File: design/btpl_cell.sv
// One cell of the address bit chain: holds one address bit and passes it
// to its neighbor toward the MSB end on each trie step. Uses btpl_pkg.
module btpl_cell
	import btpl_pkg::*;
(
	input  logic clk,
	input  logic load,
	input  logic shift,
	input  logic load_bit,
	input  logic shift_in,
	output logic tap
);

	logic bit_q;

	// load a fresh address bit, or take the neighbor's bit on a step
	always_ff @(posedge clk) begin
		if (load) begin
			bit_q <= load_bit;
		end else if (shift) begin
			bit_q <= shift_in;
		end
	end

	assign tap = bit_q;

endmodule

// File: design/binary_trie_prefix_lookup_top.sv
// Longest-prefix-match route table built as a binary trie in a node pool.
// Depends on btpl_pkg and btpl_cell.
//
// Usage:
//   in channel (in_valid/in_ready/in_item): a lookup or a route insert.
//   out channel (out_valid/out_ready/out_item): one result item per input.
//   One item is worked on at a time; in_ready is high only when idle.
//   The address sits in a chain of 32 bit cells that shifts one place per
//   trie level, so the head cell always shows the bit for the current level.
//   The walker visits one node per cycle through the registered read port
//   of the node memory, apart from the allocate step of an insert.
//   An insert walks the existing levels, then adds each new node through
//   an allocate state followed by a walk step on the fresh node.
//   The result sits in an output register, so the next item can be taken
//   while it waits; a stalled receiver holds the block in its final state.
// Reset:
//   The root node lives in flip-flops and is cleared at once; the pool
//   allocator restarts at node 1. Pool entries are written when allocated,
//   so no clearing pass is needed and the block is ready right after reset.
module binary_trie_prefix_lookup_top
	import btpl_pkg::*;
#(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	parameter int PORT_BITS = PORT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	localparam int IDXW = $clog2(NODE_COUNT);
	localparam int CNTW = IDXW + 1;

	typedef struct packed {
		logic                 route;
		logic [PORT_BITS-1:0] port;
		logic [IDXW-1:0]      child1;
		logic [IDXW-1:0]      child0;
	} node_t;

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_ALLOC, ST_DONE} state_t;

	state_t               state_q;
	logic                 op_q;
	logic [DEPTH_BITS-1:0] plen_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic [PORT_BITS-1:0] rport_q;
	logic [IDXW-1:0]      cur_q;
	logic [IDXW-1:0]      alloc_idx_q;
	logic [CNTW-1:0]      next_free_q;
	logic                 fresh_q;
	logic                 found_q;
	logic [PORT_BITS-1:0] port_q;
	node_t                root_q;
	node_t                rdata_q;
	out_item_t            res_q;
	out_item_t            out_item_q;
	logic                 out_valid_q;

	node_t mem [NODE_COUNT];

	// address bit chain
	logic [ADDR_BITS-1:0] taps;
	logic                 chain_load;
	logic                 chain_shift;

	for (genvar i = 0; i < ADDR_BITS; i++) begin : g_cells
		logic prev_bit;
		if (i == 0) begin : g_tail
			assign prev_bit = 1'b0;
		end else begin : g_link
			assign prev_bit = taps[i-1];
		end
		btpl_cell u_cell (
			.clk      (clk),
			.load     (chain_load),
			.shift    (chain_shift),
			.load_bit (in_item.ip_address[i]),
			.shift_in (prev_bit),
			.tap      (taps[i])
		);
	end

	// current node and its child on the current address bit
	node_t           node;
	logic            cur_bit;
	logic [IDXW-1:0] child;
	logic            at_bottom;
	logic            ins_here;
	logic            pool_full;
	logic            lookup_stop;
	logic            found_n;
	logic [PORT_BITS-1:0] port_n;
	logic [DEPTH_BITS-1:0] plen_sat;

	always_comb begin
		if (cur_q == '0) begin
			node = root_q;
		end else if (fresh_q) begin
			node = '0;
		end else begin
			node = rdata_q;
		end
		cur_bit = taps[ADDR_BITS-1];
		child = cur_bit ? node.child1 : node.child0;
		at_bottom = (depth_q == DEPTH_BITS'(ADDR_BITS));
		ins_here = (depth_q == plen_q);
		pool_full = (next_free_q == CNTW'(NODE_COUNT));
		lookup_stop = at_bottom || (child == '0);
		found_n = found_q | node.route;
		port_n = node.route ? node.port : port_q;
		plen_sat = (in_item.prefix_length > 6'(ADDR_BITS)) ?
			DEPTH_BITS'(ADDR_BITS) : in_item.prefix_length;
	end

	assign in_ready = (state_q == ST_IDLE);
	assign chain_load = in_valid && in_ready;

	// step down one level when the walk follows an existing or newly allocated child
	always_comb begin
		chain_shift = 1'b0;
		if (state_q == ST_ALLOC) begin
			chain_shift = 1'b1;
		end else if (state_q == ST_WALK) begin
			if (op_q == OP_LOOKUP) begin
				chain_shift = !lookup_stop;
			end else begin
				chain_shift = !ins_here && (child != '0);
			end
		end
	end

	// node memory write selection
	logic            mem_we;
	logic [IDXW-1:0] mem_waddr;
	node_t           mem_wdata;

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = node;
		if (state_q == ST_ALLOC) begin
			mem_we = 1'b1;
			mem_waddr = alloc_idx_q;
			mem_wdata = '0;
		end else if (state_q == ST_WALK && op_q == OP_INSERT && cur_q != '0) begin
			if (ins_here) begin
				mem_we = 1'b1;
				mem_wdata.route = 1'b1;
				mem_wdata.port = rport_q;
			end else if (child == '0 && !pool_full) begin
				mem_we = 1'b1;
				if (cur_bit) begin
					mem_wdata.child1 = next_free_q[IDXW-1:0];
				end else begin
					mem_wdata.child0 = next_free_q[IDXW-1:0];
				end
			end
		end
	end

	// node memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[child];
	end

	// walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			next_free_q <= CNTW'(1);
			root_q <= '0;
			out_valid_q <= 1'b0;
			fresh_q <= 1'b0;
			cur_q <= '0;
		end else begin
			// the done state reloads the output register itself
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q <= in_item.operation;
						plen_q <= plen_sat;
						rport_q <= PORT_BITS'(in_item.route_port);
						cur_q <= '0;
						depth_q <= '0;
						fresh_q <= 1'b0;
						found_q <= 1'b0;
						port_q <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (op_q == OP_LOOKUP) begin
						found_q <= found_n;
						port_q <= port_n;
						if (lookup_stop) begin
							res_q.found <= found_n;
							res_q.port <= 16'(port_n);
							res_q.status <= STATUS_OK;
							state_q <= ST_DONE;
						end else begin
							cur_q <= child;
							depth_q <= depth_q + 1'b1;
							fresh_q <= 1'b0;
						end
					end else if (ins_here) begin
						if (cur_q == '0) begin
							root_q.route <= 1'b1;
							root_q.port <= rport_q;
						end
						res_q <= '{found: 1'b0, port: '0, status: STATUS_OK};
						state_q <= ST_DONE;
					end else if (child != '0) begin
						cur_q <= child;
						depth_q <= depth_q + 1'b1;
						fresh_q <= 1'b0;
					end else if (pool_full) begin
						res_q <= '{found: 1'b0, port: '0, status: STATUS_FULL};
						state_q <= ST_DONE;
					end else begin
						if (cur_q == '0) begin
							if (cur_bit) begin
								root_q.child1 <= next_free_q[IDXW-1:0];
							end else begin
								root_q.child0 <= next_free_q[IDXW-1:0];
							end
						end
						alloc_idx_q <= next_free_q[IDXW-1:0];
						next_free_q <= next_free_q + 1'b1;
						state_q <= ST_ALLOC;
					end
				end
				ST_ALLOC: begin
					cur_q <= alloc_idx_q;
					depth_q <= depth_q + 1'b1;
					fresh_q <= 1'b1;
					state_q <= ST_WALK;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_item_q <= res_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

endmodule
